FILE: rtl/sgs_pkg.sv
package sgs_pkg;

	localparam logic       REQ_PUSH   = 1'b0;
	localparam logic       REQ_PACKET = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic       KIND_HDR  = 1'b0;
	localparam logic       KIND_DATA = 1'b1;

	localparam logic [1:0] REG_MAX_PKT = 2'd0;
	localparam logic [1:0] REG_HDR     = 2'd1;
	localparam logic [1:0] REG_MAX_TX  = 2'd2;
	localparam logic [1:0] REG_GROUP   = 2'd3;

	typedef struct packed {
		logic        is_pkt;
		logic [63:0] addr;
		logic [23:0] size;
		logic        new_payload;
	} cmd_t;

	typedef struct packed {
		logic [15:0] max_packet_bytes;
		logic [9:0]  header_bytes;
		logic [4:0]  max_tx_entries;
		logic [15:0] group_bytes;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        kind;
		logic [63:0] addr;
		logic [23:0] len;
		logic [31:0] seq;
		logic [31:0] ident;
		logic        ptype;
		logic [31:0] poff;
		logic        last;
		logic        lor;
	} desc_t;

endpackage

FILE: rtl/sgs_front.sv
module sgs_front import sgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        req_type,
	input  logic [63:0] entry_addr,
	input  logic [23:0] entry_size,
	input  logic        new_payload,
	input  logic [63:0] header_addr,
	output cmd_t        cmd,
	output logic        cmd_avail,
	input  logic        cmd_pop
);

	cmd_t       slot_q [2];
	cmd_t       dec;
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign cmd_stall = (cnt_q == 2'd2);
	assign cmd_avail = (cnt_q != 2'd0);
	assign push      = cmd_valid && !cmd_stall;
	assign cmd       = slot_q[rp_q];

	always_comb begin
		dec.is_pkt      = (req_type == REQ_PACKET);
		dec.addr        = dec.is_pkt ? header_addr : entry_addr;
		dec.size        = entry_size;
		dec.new_payload = new_payload;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (cmd_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

endmodule

FILE: rtl/sgs_budget.sv
module sgs_budget import sgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        restart,
	output logic [15:0] budget,
	output logic        budget_ok
);

	logic        run_q;
	logic [3:0]  cnt_q;
	logic [16:0] rem_q;
	logic [15:0] base;
	logic [16:0] rem_sh;
	logic        ge;

	// payload room before rounding
	assign base   = (16'(cfg.header_bytes) < cfg.max_packet_bytes) ?
		cfg.max_packet_bytes - 16'(cfg.header_bytes) : 16'd0;
	assign rem_sh = {rem_q[15:0], base[cnt_q]};
	assign ge     = rem_sh >= {1'b0, cfg.group_bytes};

	assign budget = (cfg.group_bytes != 16'd0 && cfg.group_bytes <= base) ?
		base - rem_q[15:0] : base;
	assign budget_ok = !run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b1;
			cnt_q <= 4'd15;
			rem_q <= '0;
		end else if (restart) begin
			run_q <= 1'b1;
			cnt_q <= 4'd15;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? rem_sh - {1'b0, cfg.group_bytes} : rem_sh;
			if (cnt_q == 4'd0) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

endmodule

FILE: rtl/sgs_back.sv
module sgs_back import sgs_pkg::*; #(
	parameter int SRC_QUEUE_DEPTH    = 32,
	parameter int MAX_PACKET_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_avail,
	output logic        cmd_pop,
	input  cfg_t        cfg,
	input  logic [15:0] budget,
	input  logic        budget_ok,
	output logic        desc_valid,
	input  logic        desc_stall,
	output desc_t       desc
);

	localparam int QW        = $clog2(SRC_QUEUE_DEPTH);
	localparam int CW        = $clog2(SRC_QUEUE_DEPTH + 1);
	localparam int BUF_DEPTH = (MAX_PACKET_ENTRIES < 16) ? MAX_PACKET_ENTRIES : 16;
	localparam int BW        = $clog2(BUF_DEPTH);
	localparam logic [QW-1:0] LAST_IDX = QW'(SRC_QUEUE_DEPTH - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WAIT  = 3'd1;
	localparam logic [2:0] S_PIECE = 3'd2;
	localparam logic [2:0] S_HDR   = 3'd3;
	localparam logic [2:0] S_DAT   = 3'd4;

	logic [2:0]    state_q;
	logic [QW-1:0] head_q;
	logic [QW-1:0] tail_q;
	logic [CW-1:0] qcnt_q;
	logic [23:0]   hoff_q;
	logic          type_q;
	logic [31:0]   seq_q;
	logic [31:0]   ident_q;
	logic [31:0]   ooff_q;
	logic [15:0]   acc_q;
	logic [BW-1:0] nd_q;
	logic [BW-1:0] rd_q;
	logic          last_q;
	logic          ov_q;
	desc_t         od_q;

	logic [63:0]   hdr_addr_q;
	logic [31:0]   seq0_q;
	logic [31:0]   ident0_q;
	logic          type0_q;
	logic [31:0]   off0_q;

	logic [63:0]   sa_mem [SRC_QUEUE_DEPTH];
	logic [23:0]   ss_mem [SRC_QUEUE_DEPTH];
	logic [63:0]   sa_rd_q;
	logic [23:0]   ss_rd_q;
	logic [63:0]   ba_mem [BUF_DEPTH];
	logic [23:0]   bl_mem [BUF_DEPTH];
	logic [63:0]   ba_rd_q;
	logic [23:0]   bl_rd_q;

	logic          can_load;
	logic          full;
	logic [23:0]   rest;
	logic [15:0]   room;
	logic [23:0]   piece;
	logic          consumed;
	logic [4:0]    lim;
	logic          more;
	logic [QW-1:0] head_nx;
	logic [QW-1:0] tail_nx;
	logic [BW-1:0] rd_nx;
	logic          src_we;
	logic [QW-1:0] src_wa;
	logic          buf_we;
	logic          ld;
	desc_t         d;

	assign can_load = !ov_q || !desc_stall;
	assign full     = (qcnt_q == CW'(SRC_QUEUE_DEPTH));
	assign rest     = (ss_rd_q > hoff_q) ? ss_rd_q - hoff_q : 24'd0;
	assign room     = budget - acc_q;
	assign piece    = (rest < {8'd0, room}) ? rest : {8'd0, room};
	assign consumed = (hoff_q + piece) >= ss_rd_q;
	assign lim      = (cfg.max_tx_entries > 5'(BUF_DEPTH)) ? 5'(BUF_DEPTH) : cfg.max_tx_entries;
	assign more     = (acc_q < budget) && ((7'(nd_q) + 7'd1) < 7'(lim)) && (qcnt_q != '0);
	assign head_nx  = (head_q == LAST_IDX) ? '0 : head_q + QW'(1);
	assign tail_nx  = (tail_q == LAST_IDX) ? '0 : tail_q + QW'(1);

	assign cmd_pop = (state_q == S_IDLE) && cmd_avail &&
		((!cmd.is_pkt || qcnt_q == '0) ? can_load : budget_ok);
	assign src_we  = cmd_pop && !cmd.is_pkt && !full;
	assign src_wa  = cmd.new_payload ? '0 : tail_q;
	assign buf_we  = (state_q == S_PIECE) && more;

	always_comb begin
		if (state_q == S_DAT) begin
			rd_nx = can_load ? rd_q + BW'(1) : rd_q;
		end else begin
			rd_nx = '0;
		end
	end

	always_comb begin
		ld       = 1'b0;
		d        = '0;
		d.seq    = seq0_q;
		d.ident  = ident0_q;
		d.ptype  = type0_q;
		d.poff   = off0_q;
		d.last   = last_q;
		case (state_q)
			S_IDLE: begin
				d = '0;
				d.lor = 1'b1;
				if (cmd_avail && can_load) begin
					if (!cmd.is_pkt) begin
						ld       = 1'b1;
						d.status = full ? ST_FULL : ST_OK;
					end else if (qcnt_q == '0) begin
						ld       = 1'b1;
						d.status = ST_EMPTY;
					end
				end
			end
			S_HDR: begin
				ld     = can_load;
				d.kind = KIND_HDR;
				d.addr = hdr_addr_q;
				d.len  = 24'(cfg.header_bytes);
				d.lor  = (nd_q == '0);
			end
			S_DAT: begin
				ld     = can_load;
				d.kind = KIND_DATA;
				d.addr = ba_rd_q;
				d.len  = bl_rd_q;
				d.lor  = (rd_q == nd_q - BW'(1));
			end
			default: begin
				ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (src_we) begin
			sa_mem[src_wa] <= cmd.addr;
			ss_mem[src_wa] <= cmd.size;
		end
		sa_rd_q <= sa_mem[head_q];
		ss_rd_q <= ss_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			ba_mem[nd_q] <= sa_rd_q + 64'(hoff_q);
			bl_mem[nd_q] <= piece;
		end
		ba_rd_q <= ba_mem[rd_nx];
		bl_rd_q <= bl_mem[rd_nx];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.is_pkt) begin
			hdr_addr_q <= cmd.addr;
			seq0_q     <= seq_q;
			ident0_q   <= ident_q;
			type0_q    <= type_q;
			off0_q     <= ooff_q;
		end
		if (ld) begin
			od_q <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ld) begin
			ov_q <= 1'b1;
		end else if (!desc_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			qcnt_q  <= '0;
			hoff_q  <= '0;
			type_q  <= 1'b0;
			seq_q   <= '0;
			ident_q <= '0;
			ooff_q  <= '0;
			acc_q   <= '0;
			nd_q    <= '0;
			rd_q    <= '0;
			last_q  <= 1'b0;
		end else begin
			rd_q <= rd_nx;
			case (state_q)
				S_IDLE: begin
					if (src_we) begin
						if (cmd.new_payload) begin
							head_q <= '0;
							tail_q <= QW'(1);
							qcnt_q <= CW'(1);
							hoff_q <= '0;
							type_q <= 1'b0;
							seq_q  <= '0;
							ooff_q <= '0;
						end else begin
							tail_q <= tail_nx;
							qcnt_q <= qcnt_q + CW'(1);
						end
					end else if (cmd_pop && cmd.is_pkt && qcnt_q != '0) begin
						acc_q   <= '0;
						nd_q    <= '0;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= S_PIECE;
				end
				S_PIECE: begin
					if (more) begin
						nd_q   <= nd_q + BW'(1);
						acc_q  <= acc_q + piece[15:0];
						ooff_q <= ooff_q + 32'(piece);
						if (consumed) begin
							head_q  <= head_nx;
							qcnt_q  <= qcnt_q - CW'(1);
							hoff_q  <= '0;
							state_q <= S_WAIT;
						end else begin
							hoff_q <= hoff_q + piece;
						end
					end else begin
						last_q <= (qcnt_q == '0);
						if (qcnt_q != '0) begin
							type_q <= 1'b1;
						end
						seq_q   <= seq_q + 32'd1;
						ident_q <= ident_q + 32'd1;
						state_q <= S_HDR;
					end
				end
				S_HDR: begin
					if (can_load) begin
						state_q <= (nd_q == '0) ? S_IDLE : S_DAT;
					end
				end
				S_DAT: begin
					if (can_load && rd_q == nd_q - BW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign desc_valid = ov_q;
	assign desc       = od_q;

endmodule

FILE: rtl/sgl_packet_segmenter.sv
// scatter-gather packet segmenter
// cmd channel (cmd_valid/cmd_stall): one beat is either a push of a source
// entry (req_type 0) or a request for the next packet (req_type 1).
// desc channel (desc_valid/desc_stall): a push or an error gives one beat;
// a packet request gives a header descriptor followed by its data
// descriptors, one beat per cycle while desc_stall is low, last_of_run set on the final one.
// a push is handled straight from idle; a packet first cuts each source
// entry it touches (a wait state, then the piece state), then emits its
// descriptors; the back end takes no new command until the packet is done.
// the cutting loop reads the source queue through one registered port.
// a bit-serial remainder unit recomputes the payload budget after any
// register write or reset; packets wait for it unless the queue is empty.
// reset empties the source queue and clears the back end's counters; registers
// return to their defaults.
// a stalled desc beat holds in the output register; the two-entry command
// queue keeps taking cmd beats until it fills, then raises cmd_stall.
module sgl_packet_segmenter import sgs_pkg::*; #(
	parameter int SRC_QUEUE_DEPTH    = 32,
	parameter int MAX_PACKET_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        req_type,
	input  logic [63:0] entry_addr,
	input  logic [23:0] entry_size,
	input  logic        new_payload,
	input  logic [63:0] header_addr,
	output logic        desc_valid,
	input  logic        desc_stall,
	output logic [1:0]  status,
	output logic        entry_kind,
	output logic [63:0] out_addr,
	output logic [23:0] out_len,
	output logic [31:0] packet_seq,
	output logic [31:0] packet_ident,
	output logic        payload_mode,
	output logic [31:0] payload_offset,
	output logic        last_packet,
	output logic        last_of_run
);

	cfg_t        cfg_q;
	logic        cfg_wr;
	cmd_t        cmd;
	logic        cmd_avail;
	logic        cmd_pop;
	logic [15:0] budget;
	logic        budget_ok;
	desc_t       desc;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_packet_bytes <= 16'd8192;
			cfg_q.header_bytes     <= 10'd64;
			cfg_q.max_tx_entries   <= 5'd16;
			cfg_q.group_bytes      <= 16'd0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MAX_PKT: cfg_q.max_packet_bytes <= pwdata[15:0];
				REG_HDR:     cfg_q.header_bytes     <= pwdata[9:0];
				REG_MAX_TX:  cfg_q.max_tx_entries   <= pwdata[4:0];
				REG_GROUP:   cfg_q.group_bytes      <= pwdata[15:0];
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MAX_PKT: prdata = 32'(cfg_q.max_packet_bytes);
			REG_HDR:     prdata = 32'(cfg_q.header_bytes);
			REG_MAX_TX:  prdata = 32'(cfg_q.max_tx_entries);
			REG_GROUP:   prdata = 32'(cfg_q.group_bytes);
			default:     prdata = '0;
		endcase
	end

	sgs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.req_type    (req_type),
		.entry_addr  (entry_addr),
		.entry_size  (entry_size),
		.new_payload (new_payload),
		.header_addr (header_addr),
		.cmd         (cmd),
		.cmd_avail   (cmd_avail),
		.cmd_pop     (cmd_pop)
	);

	sgs_budget u_budget (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.restart   (cfg_wr),
		.budget    (budget),
		.budget_ok (budget_ok)
	);

	sgs_back #(
		.SRC_QUEUE_DEPTH    (SRC_QUEUE_DEPTH),
		.MAX_PACKET_ENTRIES (MAX_PACKET_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cmd_avail  (cmd_avail),
		.cmd_pop    (cmd_pop),
		.cfg        (cfg_q),
		.budget     (budget),
		.budget_ok  (budget_ok),
		.desc_valid (desc_valid),
		.desc_stall (desc_stall),
		.desc       (desc)
	);

	assign status         = desc.status;
	assign entry_kind     = desc.kind;
	assign out_addr       = desc.addr;
	assign out_len        = desc.len;
	assign packet_seq     = desc.seq;
	assign packet_ident   = desc.ident;
	assign payload_mode   = desc.ptype;
	assign payload_offset = desc.poff;
	assign last_packet    = desc.last;
	assign last_of_run    = desc.lor;

`ifndef SYNTH
	a_budget_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !budget_ok)
		else $error("budget not recomputed after register write");

	a_budget_range: assert property (@(posedge clk) disable iff (!arst_n)
		budget_ok |-> budget <= cfg_q.max_packet_bytes)
		else $error("budget exceeds packet size");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		desc_valid && status != ST_OK |-> last_of_run && entry_kind == KIND_HDR &&
			out_len == 24'd0)
		else $error("error beat malformed");
`endif

endmodule
